>>> rtl/core/crsp_pkg.sv
// shared types, constants and helpers for the chroma rotate/scale pixel unit
// no dependencies; imported by every module of the block but crsp_checker
`default_nettype none

package crsp_pkg;

    // number of register stages from input to output
    localparam int NSTG = 6;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_U  = 3'd0,
        CFG_CENTER_V  = 3'd1,
        CFG_COEF_UU   = 3'd2,
        CFG_COEF_UV   = 3'd3,
        CFG_COEF_VU   = 3'd4,
        CFG_COEF_VV   = 3'd5,
        CFG_LIMITS    = 3'd6,
        CFG_DRIVE     = 3'd7
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [7:0]         RST_CENTER = 8'd128;
    localparam logic signed [16:0] RST_COEF_D = 17'sd4095;
    localparam logic signed [16:0] RST_COEF_X = 17'sd71;
    localparam logic [15:0]        RST_LIMITS = 16'hF010;
    localparam logic [31:0]        RST_DRIVE  = 32'h4000_0400;

    // saturation bounds, Q8
    localparam logic [9:0] SAT_MIN = 10'd256;
    localparam logic [9:0] SAT_MAX = 10'd560;

    // decoded settings as the datapath sees them
    typedef struct packed {
        logic [7:0]         cu;
        logic [7:0]         cv;
        logic signed [16:0] cuu;
        logic signed [16:0] cuv;
        logic signed [16:0] cvu;
        logic signed [16:0] cvv;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic [10:0]        co;
        logic [10:0]        si;
        logic [9:0]         sat;
    } t_cfg;

    // clamp a signed offset-added value to [lo,hi]
    function automatic logic [7:0] clamp8(logic signed [15:0] x, logic [7:0] lo,
                                          logic [7:0] hi);
        logic [7:0] r;
        priority if (x < $signed({8'd0, lo})) begin
            r = lo;
        end else if (x > $signed({8'd0, hi})) begin
            r = hi;
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/crsp_cfg.sv
// configuration register file with limit swap and saturation clamp
// depends on crsp_pkg
`default_nettype none

module crsp_cfg
    import crsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    logic [7:0]         r_cu, r_cv;
    logic signed [16:0] r_cuu, r_cuv, r_cvu, r_cvv;
    logic [15:0]        r_lim;
    logic [31:0]        r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cu    <= RST_CENTER;
            r_cv    <= RST_CENTER;
            r_cuu   <= RST_COEF_D;
            r_cuv   <= -RST_COEF_X;
            r_cvu   <= RST_COEF_X;
            r_cvv   <= RST_COEF_D;
            r_lim   <= RST_LIMITS;
            r_drive <= RST_DRIVE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_U: r_cu    <= i_cfg_data[7:0];
                CFG_CENTER_V: r_cv    <= i_cfg_data[7:0];
                CFG_COEF_UU:  r_cuu   <= $signed(i_cfg_data[16:0]);
                CFG_COEF_UV:  r_cuv   <= $signed(i_cfg_data[16:0]);
                CFG_COEF_VU:  r_cvu   <= $signed(i_cfg_data[16:0]);
                CFG_COEF_VV:  r_cvv   <= $signed(i_cfg_data[16:0]);
                CFG_LIMITS:   r_lim   <= i_cfg_data[15:0];
                CFG_DRIVE:    r_drive <= i_cfg_data;
                default:      r_cu    <= r_cu;
            endcase
        end
    end

    logic [9:0] sat_raw;
    logic       swap;

    always_comb begin
        sat_raw       = r_drive[31:22];
        swap          = r_lim[7:0] > r_lim[15:8];
        o_cfg.cu      = r_cu;
        o_cfg.cv      = r_cv;
        o_cfg.cuu     = r_cuu;
        o_cfg.cuv     = r_cuv;
        o_cfg.cvu     = r_cvu;
        o_cfg.cvv     = r_cvv;
        o_cfg.lo      = swap ? r_lim[15:8] : r_lim[7:0];
        o_cfg.hi      = swap ? r_lim[7:0] : r_lim[15:8];
        o_cfg.co      = r_drive[10:0];
        o_cfg.si      = r_drive[21:11];
        priority if (sat_raw < SAT_MIN) begin
            o_cfg.sat = SAT_MIN;
        end else if (sat_raw > SAT_MAX) begin
            o_cfg.sat = SAT_MAX;
        end else begin
            o_cfg.sat = sat_raw;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/crsp_ctl.sv
// pipeline control: valid bits, per-stage enables and the frame marker line
// depends on crsp_pkg
`default_nettype none

module crsp_ctl
    import crsp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic            i_s_tlast,
    input  wire logic            i_m_tready,
    output logic                 o_s_tready,
    output logic [NSTG-1:0]      o_en,
    output logic                 o_m_tvalid,
    output logic                 o_m_tlast
);

    logic [NSTG-1:0] r_vld, n_vld;
    logic [NSTG-1:0] r_last, n_last;

    // a stage moves when it is empty or its successor moves (bubbles collapse)
    always_comb begin
        o_en[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            o_en[k] = !r_vld[k] || o_en[k+1];
        end
    end

    always_comb begin
        n_vld  = r_vld;
        n_last = r_last;
        for (int k = 0; k < NSTG; k++) begin
            if (o_en[k]) begin
                n_vld[k]  = (k == 0) ? i_s_tvalid : r_vld[(k == 0) ? 0 : k - 1];
                n_last[k] = (k == 0) ? i_s_tlast  : r_last[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
    end

    assign o_s_tready = o_en[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tlast  = r_last[NSTG-1];

endmodule

`default_nettype wire

>>> rtl/core/crsp_matrix.sv
// stage one: centered Q12 gain/rotation matrix, rounding and clamp (2 stages)
// depends on crsp_pkg
`default_nettype none

module crsp_matrix
    import crsp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic [NSTG-1:0] i_en,
    input  wire logic [7:0]      i_u,
    input  wire logic [7:0]      i_v,
    input  wire t_cfg            i_cfg,
    output logic [7:0]           o_u,
    output logic [7:0]           o_v
);

    logic signed [8:0]  du, dv;
    logic signed [16:0] cuu, cuv, cvu, cvv;
    logic signed [25:0] n_puu, n_puv, n_pvu, n_pvv;
    logic signed [25:0] r_puu, r_puv, r_pvu, r_pvv;
    logic signed [26:0] su, sv;
    logic signed [15:0] tu, tv;
    logic [7:0]         n_u, n_v, r_u, r_v;

    // products
    always_comb begin
        cuu   = i_cfg.cuu;
        cuv   = i_cfg.cuv;
        cvu   = i_cfg.cvu;
        cvv   = i_cfg.cvv;
        du    = $signed({1'b0, i_u}) - $signed({1'b0, i_cfg.cu});
        dv    = $signed({1'b0, i_v}) - $signed({1'b0, i_cfg.cv});
        n_puu = 26'(du) * 26'(cuu);
        n_puv = 26'(dv) * 26'(cuv);
        n_pvu = 26'(du) * 26'(cvu);
        n_pvv = 26'(dv) * 26'(cvv);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_puu <= n_puu;
            r_puv <= n_puv;
            r_pvu <= n_pvu;
            r_pvv <= n_pvv;
        end
    end

    // sum, round half up, floor shift by 12, recenter and clamp
    always_comb begin
        su  = {r_puu[25], r_puu} + {r_puv[25], r_puv} + 27'sd2048;
        sv  = {r_pvv[25], r_pvv} + {r_pvu[25], r_pvu} + 27'sd2048;
        tu  = {su[26], su[26:12]} + 16'sd128;
        tv  = {sv[26], sv[26:12]} + 16'sd128;
        n_u = clamp8(tu, i_cfg.lo, i_cfg.hi);
        n_v = clamp8(tv, i_cfg.lo, i_cfg.hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_u <= n_u;
            r_v <= n_v;
        end
    end

    assign o_u = r_u;
    assign o_v = r_v;

endmodule

`default_nettype wire

>>> rtl/core/crsp_rotsat.sv
// stage two: Q10 rotation, Q8 saturation scale and final clamp (4 stages)
// depends on crsp_pkg
`default_nettype none

module crsp_rotsat
    import crsp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic [NSTG-1:0] i_en,
    input  wire logic [7:0]      i_u,
    input  wire logic [7:0]      i_v,
    input  wire t_cfg            i_cfg,
    output logic [7:0]           o_u,
    output logic [7:0]           o_v
);

    logic signed [8:0]  eu, ev;
    logic signed [11:0] co, si;
    logic signed [10:0] sat;
    logic signed [20:0] n_puc, n_pvs, n_pvc, n_pus;
    logic signed [20:0] r_puc, r_pvs, r_pvc, r_pus;
    logic signed [21:0] su, sv;
    logic signed [11:0] n_ru, n_rv, r_ru, r_rv;
    logic signed [22:0] n_pu, n_pv, r_pu, r_pv;
    logic signed [22:0] fu, fv;
    logic signed [15:0] tu, tv;
    logic [7:0]         n_u, n_v, r_u, r_v;

    // rotation products
    always_comb begin
        eu    = $signed({1'b0, i_u}) - 9'sd128;
        ev    = $signed({1'b0, i_v}) - 9'sd128;
        co    = $signed({1'b0, i_cfg.co});
        si    = $signed({1'b0, i_cfg.si});
        n_puc = 21'(eu) * 21'(co);
        n_pvs = 21'(ev) * 21'(si);
        n_pvc = 21'(ev) * 21'(co);
        n_pus = 21'(eu) * 21'(si);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_puc <= n_puc;
            r_pvs <= n_pvs;
            r_pvc <= n_pvc;
            r_pus <= n_pus;
        end
    end

    // combine and round to integer offsets
    always_comb begin
        su   = {r_puc[20], r_puc} - {r_pvs[20], r_pvs} + 22'sd512;
        sv   = {r_pvc[20], r_pvc} + {r_pus[20], r_pus} + 22'sd512;
        n_ru = su[21:10];
        n_rv = sv[21:10];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_ru <= n_ru;
            r_rv <= n_rv;
        end
    end

    // saturation products
    always_comb begin
        sat  = $signed({1'b0, i_cfg.sat});
        n_pu = 23'(r_ru) * 23'(sat);
        n_pv = 23'(r_rv) * 23'(sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_pu <= n_pu;
            r_pv <= n_pv;
        end
    end

    // round, recenter and clamp
    always_comb begin
        fu  = r_pu + 23'sd128;
        fv  = r_pv + 23'sd128;
        tu  = {fu[22], fu[22:8]} + 16'sd128;
        tv  = {fv[22], fv[22:8]} + 16'sd128;
        n_u = clamp8(tu, i_cfg.lo, i_cfg.hi);
        n_v = clamp8(tv, i_cfg.lo, i_cfg.hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_u <= n_u;
            r_v <= n_v;
        end
    end

    assign o_u = r_u;
    assign o_v = r_v;

endmodule

`default_nettype wire

>>> rtl/core/chroma_rotate_scale_pixel_unit.sv
// top level of the chroma rotate/scale pixel unit
// depends on crsp_pkg, crsp_cfg, crsp_ctl, crsp_matrix, crsp_rotsat
//
// Corrects one (U,V) chroma pair per transaction. Stage one removes the
// programmed centers, applies a signed Q12 gain/rotation matrix, rounds,
// recenters on 128 and clamps to the programmed limits (swapped if given
// reversed). Stage two rotates the offsets from 128 by Q10 cos/sin, scales
// by a Q8 saturation factor (held to 256..560), recenters and clamps again.
// The unit takes one transaction every clock unless all stages are full and
// the output stalls; from acceptance to output valid, six register stages
// (matrix products, then round and clamp for stage one; rotation products,
// rounding, saturation products, then round and clamp into the output
// register for stage two) each hold one pixel and move independently, so
// empty stages fill while the output waits. tlast rides along unchanged.
// Configuration writes take effect on the next clock and should be made
// while no pixel is in flight.
`default_nettype none

module chroma_rotate_scale_pixel_unit
    import crsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // u_in [7:0], v_in [15:8]
    input  wire logic        s_tlast,   // last_in
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // u_out [7:0], v_out [15:8]
    output logic             m_tlast    // last_out
);

    t_cfg            cfg;
    logic [NSTG-1:0] en;
    logic [7:0]      u1, v1;
    logic [7:0]      u2, v2;

    // register file, limit ordering and saturation clamp
    crsp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // handshake and stage enables
    crsp_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tlast  (s_tlast),
        .i_m_tready (m_tready),
        .o_s_tready (s_tready),
        .o_en       (en),
        .o_m_tvalid (m_tvalid),
        .o_m_tlast  (m_tlast)
    );

    // stage one: matrix about the centers
    crsp_matrix u_matrix (
        .i_clk (i_clk),
        .i_en  (en),
        .i_u   (s_tdata[7:0]),
        .i_v   (s_tdata[15:8]),
        .i_cfg (cfg),
        .o_u   (u1),
        .o_v   (v1)
    );

    // stage two: hue rotation and saturation, output register inside
    crsp_rotsat u_rotsat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_u   (u1),
        .i_v   (v1),
        .i_cfg (cfg),
        .o_u   (u2),
        .o_v   (v2)
    );

    assign m_tdata = {v2, u2};

endmodule

`default_nettype wire

>>> rtl/core/crsp_checker.sv
// port-level checks for the chroma rotate/scale pixel unit, bound to the top
// depends on chroma_rotate_scale_pixel_unit
`default_nettype none

module crsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // pipeline is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    // an idle or draining output means every stage can move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side is free");

    // stalled output transaction stays
    a_hold_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output transaction dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("output payload changed under stall");

endmodule

bind chroma_rotate_scale_pixel_unit crsp_checker u_crsp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/chroma_rotate_scale_pixel_unit_tb.sv
// self-checking testbench for chroma_rotate_scale_pixel_unit
// depends on crsp_pkg and the unit's rtl; predicts every corrected chroma pair
// from a mirror of the registers and checks the output stream in order
module chroma_rotate_scale_pixel_unit_tb;
    import crsp_pkg::*;

    // one chroma pair as it travels on either stream
    typedef struct packed {
        logic [7:0] u;
        logic [7:0] v;
        logic       last;
    } pixel_t;

    // directed stimulus row; known marks a hand-computed result at reset settings
    typedef struct packed {
        logic [7:0] u;
        logic [7:0] v;
        logic       last;
        logic       known;
        logic [7:0] ku;
        logic [7:0] kv;
    } dir_row_t;

    // one value per register, in register index order
    typedef logic [31:0] reg_set_t [8];

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 78;
    localparam int DIR_ROWS    = 8;

    // directed pixels: centers, corners, and alternating bit patterns
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'd128, 8'd128, 1'b0, 1'b1, 8'd128, 8'd128},  // centered pair stays put
        '{8'd0,   8'd0,   1'b0, 1'b1, 8'd16,  8'd16},   // low corner hits the minimum
        '{8'd255, 8'd255, 1'b1, 1'b1, 8'd240, 8'd240},  // high corner hits the maximum
        '{8'd0,   8'd255, 1'b0, 1'b0, 8'd0,   8'd0},
        '{8'd255, 8'd0,   1'b1, 1'b0, 8'd0,   8'd0},
        '{8'd170, 8'd85,  1'b0, 1'b0, 8'd0,   8'd0},
        '{8'd85,  8'd170, 1'b1, 1'b0, 8'd0,   8'd0},
        '{8'd1,   8'd254, 1'b1, 1'b0, 8'd0,   8'd0}
    };

    // dut ports, all inputs known from time zero
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = CFG_CENTER_U;
    logic [31:0] i_cfg_data = '0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata    = '0;      // u_in [7:0], v_in [15:8]
    logic        s_tlast    = 1'b0;    // last_in
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [15:0] m_tdata;              // u_out [7:0], v_out [15:8]
    logic        m_tlast;              // last_out

    // mirror of the register file, at reset values until the first write
    logic [7:0]         cfg_cen_u  = RST_CENTER;
    logic [7:0]         cfg_cen_v  = RST_CENTER;
    logic signed [16:0] cfg_uu     = RST_COEF_D;
    logic signed [16:0] cfg_uv     = -RST_COEF_X;
    logic signed [16:0] cfg_vu     = RST_COEF_X;
    logic signed [16:0] cfg_vv     = RST_COEF_D;
    logic [15:0]        cfg_limits = RST_LIMITS;
    logic [31:0]        cfg_drive  = RST_DRIVE;

    // corrected pairs still owed by the dut, oldest first
    pixel_t pending_pixels [$];

    int          snd_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_cnt     = 0;
    pixel_t      got_px;
    pixel_t      want_px;

    chroma_rotate_scale_pixel_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // expected correction of one pair under the mirrored settings
    function automatic pixel_t correct_pixel(input pixel_t px);
        longint lo, hi, tmp, du, dv, u1, v1, co, si, sat, eu, ev, ru, rv, fu, fv;
        pixel_t res;
        lo = longint'(cfg_limits[7:0]);
        hi = longint'(cfg_limits[15:8]);
        // reversed limits are swapped before use
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        // stage one: centered Q12 matrix, round half up, recenter, clamp
        du = longint'(px.u) - longint'(cfg_cen_u);
        dv = longint'(px.v) - longint'(cfg_cen_v);
        u1 = clip(((du * longint'(cfg_uu) + dv * longint'(cfg_uv) + 2048) >>> 12) + 128,
                  lo, hi);
        v1 = clip(((dv * longint'(cfg_vv) + du * longint'(cfg_vu) + 2048) >>> 12) + 128,
                  lo, hi);
        // stage two: Q10 rotation then Q8 saturation held to its legal window
        co  = longint'(cfg_drive[10:0]);
        si  = longint'(cfg_drive[21:11]);
        sat = clip(longint'(cfg_drive[31:22]), longint'(SAT_MIN), longint'(SAT_MAX));
        eu  = u1 - 128;
        ev  = v1 - 128;
        ru  = (eu * co - ev * si + 512) >>> 10;
        rv  = (ev * co + eu * si + 512) >>> 10;
        fu  = (ru * sat + 128) >>> 8;
        fv  = (rv * sat + 128) >>> 8;
        res.u    = 8'(clip(fu + 128, lo, hi));
        res.v    = 8'(clip(fv + 128, lo, hi));
        res.last = px.last;
        return res;
    endfunction

    function automatic logic [31:0] drive_word(input logic [10:0] co, input logic [10:0] si,
                                               input logic [9:0] sat);
        return {sat, si, co};
    endfunction

    // coefficient mix: near unity, range ends, anywhere in range, raw 17-bit garbage
    function automatic logic [31:0] rand_coef();
        logic [31:0] c;
        case ($urandom_range(0, 5))
            0:       c = 32'd3696 + $urandom_range(0, 800);
            1:       c = -32'sd40960;
            2:       c = 32'd40960;
            3:       c = $urandom_range(0, 81920) - 32'd40960;
            4:       c = $urandom();
            default: c = $urandom_range(0, 8192) - 32'd4096;
        endcase
        return c;
    endfunction

    // one full set of register values for a random phase
    function automatic reg_set_t random_setup();
        reg_set_t    rs;
        logic [7:0]  lo, hi;
        logic [10:0] co, si;
        logic [9:0]  sat;
        // upper data bits are left random on narrow registers to exercise masking
        rs[CFG_CENTER_U] = $urandom();
        rs[CFG_CENTER_V] = $urandom();
        if ($urandom_range(0, 2) == 0) rs[CFG_CENTER_U][7:0] = RST_CENTER;
        if ($urandom_range(0, 2) == 0) rs[CFG_CENTER_V][7:0] = RST_CENTER;
        rs[CFG_COEF_UU] = rand_coef();
        rs[CFG_COEF_UV] = rand_coef();
        rs[CFG_COEF_VU] = rand_coef();
        rs[CFG_COEF_VV] = rand_coef();
        lo = 8'($urandom());
        hi = 8'($urandom());
        case ($urandom_range(0, 4))
            0: begin
                lo = 8'h00;
                hi = 8'hff;
            end
            1: begin
                lo = 8'h10;
                hi = 8'hf0;
            end
            2: begin
                // force a reversed window
                if (lo < hi) {lo, hi} = {hi, lo};
            end
            3: hi = lo;  // window of a single value
            default: ;
        endcase
        rs[CFG_LIMITS] = $urandom();
        rs[CFG_LIMITS][15:0] = {hi, lo};
        case ($urandom_range(0, 3))
            0:       co = 11'd1024;
            1:       co = 11'h7ff;
            2:       co = 11'd0;
            default: co = 11'($urandom());
        endcase
        case ($urandom_range(0, 3))
            0:       si = 11'd0;
            1:       si = 11'h7ff;
            2:       si = 11'($urandom_range(0, 300));
            default: si = 11'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0:       sat = SAT_MIN;
            1:       sat = SAT_MAX;
            2:       sat = 10'd0;
            3:       sat = 10'h3ff;
            4:       sat = 10'($urandom_range(SAT_MIN, SAT_MAX));
            default: sat = 10'($urandom());
        endcase
        // now and then make stage two a plain pass-through
        if ($urandom_range(0, 4) == 0) begin
            co  = 11'd1024;
            si  = 11'd0;
            sat = SAT_MIN;
        end
        rs[CFG_DRIVE] = drive_word(co, si, sat);
        return rs;
    endfunction

    // writes all eight registers back to back; called only with nothing in flight
    task automatic apply_setup(input reg_set_t rs);
        int k;
        for (k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(k);
            i_cfg_data <= rs[k];
            @(posedge i_clk);
            case (t_cfg_idx'(k))
                CFG_CENTER_U: cfg_cen_u  = rs[k][7:0];
                CFG_CENTER_V: cfg_cen_v  = rs[k][7:0];
                CFG_COEF_UU:  cfg_uu     = rs[k][16:0];
                CFG_COEF_UV:  cfg_uv     = rs[k][16:0];
                CFG_COEF_VU:  cfg_vu     = rs[k][16:0];
                CFG_COEF_VV:  cfg_vv     = rs[k][16:0];
                CFG_LIMITS:   cfg_limits = rs[k][15:0];
                CFG_DRIVE:    cfg_drive  = rs[k];
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // one input transaction, with random idle cycles in front of it
    task automatic send_pixel(input pixel_t px, input pixel_t want);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {px.v, px.u};
        s_tlast  <= px.last;
        do @(posedge i_clk); while (!s_tready);
        // accepted at this edge; the mirror cannot change while pixels are in flight
        pending_pixels.push_back(want);
    endtask

    // stop sending until every owed pair has come out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    // drained and then idle for longer than the pipe is deep, so it is surely empty
    task automatic settle();
        hold_until_drained();
        repeat (NSTG + 2) @(posedge i_clk);
    endtask

    task automatic walk_table(input bit use_known);
        int     r;
        pixel_t px;
        pixel_t want;
        for (r = 0; r < DIR_ROWS; r++) begin
            px.u    = DIR_TABLE[r].u;
            px.v    = DIR_TABLE[r].v;
            px.last = DIR_TABLE[r].last;
            want    = correct_pixel(px);
            if (use_known && DIR_TABLE[r].known) begin
                want.u = DIR_TABLE[r].ku;
                want.v = DIR_TABLE[r].kv;
            end
            send_pixel(px, want);
        end
    endtask

    // mostly uniform, with the range ends picked more often
    function automatic logic [7:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic report(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // output side: compare each output transaction with the oldest expectation,
    // and stall the output at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_px.u    = m_tdata[7:0];
            got_px.v    = m_tdata[15:8];
            got_px.last = m_tlast;
            if (pending_pixels.size() == 0) begin
                $display("%0t: output transaction with nothing expected, u=%0d v=%0d last=%0d",
                         $time, got_px.u, got_px.v, got_px.last);
                mismatches++;
            end else begin
                want_px = pending_pixels.pop_front();
                report("u_out", want_px.u, got_px.u);
                report("v_out", want_px.v, got_px.v);
                report("last_out", want_px.last, got_px.last);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("chroma_rotate_scale_pixel_unit_tb failed");
            $finish;
        end
    end

    initial begin
        reg_set_t    odd_setup;
        reg_set_t    wide_setup;
        int          ph;
        int          n;
        int          frame_len;
        int          frame_pos;
        pixel_t      px;

        // extreme settings: centers at the ends, coefficients at and past the range
        // ends, reversed limits, cos/sin at full 11 bits, saturation below its floor
        odd_setup = '{32'h0000_0000, 32'h0000_00ff, 32'd40960, -32'sd40960,
                      32'hffff_0000, 32'h0000_ffff, 32'h0000_00ff,
                      drive_word(11'h7ff, 11'h7ff, 10'd0)};
        // centers swapped, pure sign flip on V, full window, saturation above its cap
        wide_setup = '{32'h0000_00ff, 32'h0000_0000, 32'd4096, 32'd0,
                       32'd0, -32'sd4096, 32'h0000_ff00,
                       drive_word(11'd0, 11'd1024, 10'h3ff)};

        // single reset at the start
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: reset settings with hand-computed results, then the extremes
        walk_table(1'b1);
        settle();
        apply_setup(odd_setup);
        walk_table(1'b0);
        settle();
        apply_setup(wide_setup);
        walk_table(1'b0);

        // random part: frames of random length under random settings per phase
        frame_len = 1;
        frame_pos = 0;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph / 3)
                0: begin
                    snd_idle_pct  = 6;
                    rcv_stall_pct = 57;
                end
                1: begin
                    snd_idle_pct  = 57;
                    rcv_stall_pct = 6;
                end
                default: begin
                    snd_idle_pct  = 0;
                    rcv_stall_pct = 0;
                end
            endcase
            settle();
            apply_setup(random_setup());
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // mid-phase pause with the whole pipe drained
                if (ph == 4 && n == PHASE_ITEMS / 2) hold_until_drained();
                px.u = rand_sample();
                px.v = rand_sample();
                frame_pos++;
                px.last = (frame_pos >= frame_len);
                if (px.last) begin
                    frame_pos = 0;
                    frame_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 32);
                end
                send_pixel(px, correct_pixel(px));
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("chroma_rotate_scale_pixel_unit_tb passed");
        end else begin
            $display("chroma_rotate_scale_pixel_unit_tb failed");
        end
        $finish;
    end

endmodule
